FILE: sv/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared constants and types for the clock frame replacer.
// ----------------------------------------------------------------------------
package cfr_pkg;

	localparam int Frames = 256;
	localparam int FrameW = $clog2(Frames);
	localparam int CountW = FrameW + 1;
	localparam int ProcW = 6;
	localparam int PageW = 8;

	localparam logic ReqAccess = 1'b0;
	localparam logic ReqFault = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FREE,
		ST_SWEEP,
		ST_READ,
		ST_DONE
	} state_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic [FrameW-1:0] sel;
		logic mark;
		logic mark_dirty;
		logic clr_ref;
		logic take;
		logic take_ref;
	} cell_ctl_t;

endpackage

FILE: sv/clock_frame_replacer_core.sv
// ----------------------------------------------------------------------------
// clock_frame_replacer_core
// Second-chance frame replacer over a chain of per-frame bit cells.
// ----------------------------------------------------------------------------
// channel   dir  handshake            word
// in        in   in_valid/in_ready    request fields
// out       out  out_valid/out_ready  fault result fields
// cfg       in   cfg_valid/cfg_ready  frames_in_use
//
// Access: sets the frame's reference bit. Fault with a free frame: free chain,
// RAM read. Fault with eviction: hand sweeps k frames (up to n+1), RAM read.
// Bits reset asynchronously; owner/page RAM holds no reset.
// Output is registered; the next request is taken once the result is taken.
// Config words are taken only while the controller is idle.
// ----------------------------------------------------------------------------
module clock_frame_replacer_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        req_type,
	input  logic [7:0]                  access_frame,
	input  logic                        access_is_write,
	input  logic [5:0]                  fault_process,
	input  logic [7:0]                  fault_page,
	input  logic                        page_is_new,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  chosen_frame,
	output logic                        took_free_frame,
	output logic [5:0]                  evicted_process,
	output logic [7:0]                  evicted_page,
	output logic                        write_back,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [8:0]                  cfg_data
);

	localparam int F = cfr_pkg::Frames;
	localparam int FW = cfr_pkg::FrameW;
	localparam int CW = cfr_pkg::CountW;
	localparam int OW = cfr_pkg::ProcW + cfr_pkg::PageW;

	cfr_pkg::state_t state_q, state_d;
	cfr_pkg::cell_ctl_t ctl;

	logic [8:0]    fiu_q;
	logic [CW-1:0] n;
	logic [FW-1:0] hand_q, hand_d, victim_q, victim_d, cur, nxt;
	logic          free_q, free_d;
	logic          req_q, wr_q, new_q;
	logic [FW-1:0] af_q;
	logic [5:0]    proc_q;
	logic [7:0]    page_q;
	logic          dirty_v_q;
	logic [F:0]    chain;
	logic [F-1:0]  ref_v, dirty_v;
	logic [F-1:0]  first_free;
	logic [FW-1:0] free_idx;
	logic          any_free;
	logic          ram_we;
	logic [OW-1:0] ram_rd;

	// clamp frames_in_use to 1..F
	always_comb begin
		if (fiu_q == 9'd0) begin
			n = CW'(1);
		end else if (CW'(fiu_q) > CW'(F)) begin
			n = CW'(F);
		end else begin
			n = CW'(fiu_q);
		end
	end

	assign chain[0] = 1'b1;
	genvar g;
	generate
		for (g = 0; g < F; g++) begin : g_cell
			cfr_cell u_cell (
				.ctl      (ctl),
				.clk      (clk),
				.arst_n   (arst_n),
				.idx      (FW'(g)),
				.in_range (CW'(g) < n),
				.free_in  (chain[g]),
				.free_out (chain[g+1]),
				.ref_bit  (ref_v[g]),
				.dirty    (dirty_v[g])
			);
			assign first_free[g] = chain[g] & ~chain[g+1];
		end
	endgenerate

	assign any_free = ~chain[F];

	always_comb begin
		free_idx = '0;
		for (int i = 0; i < F; i++) begin
			if (first_free[i]) begin
				free_idx = free_idx | FW'(i);
			end
		end
	end

	assign cur = ({1'b0, hand_q} >= n) ? '0 : hand_q;
	assign nxt = ({1'b0, cur} + CW'(1) == n) ? '0 : FW'(cur + FW'(1));

	cfr_ram #(.Width(OW), .Depth(F)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (victim_q),
		.wdata ({proc_q, page_q}),
		.rdata (ram_rd)
	);

	assign in_ready = (state_q == cfr_pkg::ST_IDLE) && !out_valid;
	assign cfg_ready = (state_q == cfr_pkg::ST_IDLE);

	always_comb begin
		state_d = state_q;
		hand_d = hand_q;
		victim_d = victim_q;
		free_d = free_q;
		ctl = '0;
		ram_we = 1'b0;
		unique case (state_q)
			cfr_pkg::ST_IDLE: begin
				if (in_valid && in_ready) begin
					state_d = (req_type == cfr_pkg::ReqFault) ? cfr_pkg::ST_FREE
						: cfr_pkg::ST_DONE;
				end
			end
			cfr_pkg::ST_FREE: begin
				if (req_q == cfr_pkg::ReqAccess) begin
					state_d = cfr_pkg::ST_IDLE;
				end else if (any_free) begin
					victim_d = free_idx;
					free_d = 1'b1;
					state_d = cfr_pkg::ST_READ;
				end else begin
					free_d = 1'b0;
					state_d = cfr_pkg::ST_SWEEP;
				end
			end
			cfr_pkg::ST_SWEEP: begin
				ctl.sel = cur;
				hand_d = nxt;
				if (ref_v[cur]) begin
					ctl.clr_ref = 1'b1;
				end else begin
					victim_d = cur;
					state_d = cfr_pkg::ST_READ;
				end
			end
			cfr_pkg::ST_READ: begin
				// RAM read of old owner/page issued this cycle
				state_d = cfr_pkg::ST_DONE;
			end
			cfr_pkg::ST_DONE: begin
				if (req_q == cfr_pkg::ReqAccess) begin
					ctl.sel = af_q;
					ctl.mark = 1'b1;
					ctl.mark_dirty = wr_q;
					state_d = cfr_pkg::ST_IDLE;
				end else begin
					ctl.sel = victim_q;
					ctl.take = 1'b1;
					ctl.take_ref = new_q;
					ram_we = 1'b1;
					state_d = cfr_pkg::ST_IDLE;
				end
			end
			default: state_d = cfr_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfr_pkg::ST_IDLE;
			fiu_q <= 9'd256;
			hand_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			hand_q <= hand_d;
			if (cfg_valid && cfg_ready) begin
				fiu_q <= cfg_data;
			end
			if (state_q == cfr_pkg::ST_DONE && req_q == cfr_pkg::ReqFault) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		victim_q <= victim_d;
		free_q <= free_d;
		if (in_valid && in_ready) begin
			req_q <= req_type;
			af_q <= access_frame;
			wr_q <= access_is_write;
			proc_q <= fault_process;
			page_q <= fault_page;
			new_q <= page_is_new;
		end
		if (state_q == cfr_pkg::ST_READ) begin
			dirty_v_q <= dirty_v[victim_q];
		end
		if (state_q == cfr_pkg::ST_DONE && req_q == cfr_pkg::ReqFault) begin
			chosen_frame <= victim_q;
			took_free_frame <= free_q;
			evicted_process <= free_q ? 6'd0 : ram_rd[OW-1:cfr_pkg::PageW];
			evicted_page <= free_q ? 8'd0 : ram_rd[cfr_pkg::PageW-1:0];
			write_back <= free_q ? 1'b0 : dirty_v_q;
		end
	end

endmodule

FILE: sv/cfr_ram.sv
// ----------------------------------------------------------------------------
// cfr_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module cfr_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: sv/cfr_cell.sv
// ----------------------------------------------------------------------------
// cfr_cell
// One frame's used, referenced and dirty bits; passes a free-search token on.
// ----------------------------------------------------------------------------
module cfr_cell (
	input  cfr_pkg::cell_ctl_t         ctl,
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [cfr_pkg::FrameW-1:0] idx,
	input  logic                       in_range,
	input  logic                       free_in,
	output logic                       free_out,
	output logic                       ref_bit,
	output logic                       dirty
);

	logic used_q, ref_q, dirty_q, hit;

	assign hit = (ctl.sel == idx);
	// free_in high means no lower frame is free
	assign free_out = free_in & (used_q | ~in_range);
	assign ref_bit = ref_q;
	assign dirty = dirty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			ref_q <= 1'b0;
			dirty_q <= 1'b0;
		end else if (hit) begin
			if (ctl.take) begin
				used_q <= 1'b1;
				ref_q <= ctl.take_ref;
				dirty_q <= 1'b0;
			end else if (ctl.mark) begin
				ref_q <= 1'b1;
				if (ctl.mark_dirty) begin
					dirty_q <= 1'b1;
				end
			end else if (ctl.clr_ref) begin
				ref_q <= 1'b0;
			end
		end
	end

endmodule

FILE: tb/clock_frame_replacer_core_test.sv
// ----------------------------------------------------------------------------
// clock_frame_replacer_core_test
// Drives access and fault words into the frame replacer, predicts each fault
// result with a behavioral frame table, and compares field by field.
// ----------------------------------------------------------------------------
module clock_frame_replacer_core_test;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] frame;
		logic       free;
		logic [5:0] proc_id;
		logic [7:0] page;
		logic       wb;
	} fault_res_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] afr;
		logic       wr;
		logic [5:0] fproc;
		logic [7:0] fpage;
		logic       isnew;
		logic       chk;   // typed-in expectation present
		fault_res_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic req_type = cfr_pkg::ReqAccess;
	logic [7:0] access_frame = '0;
	logic access_is_write = 1'b0;
	logic [5:0] fault_process = '0;
	logic [7:0] fault_page = '0;
	logic page_is_new = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] chosen_frame;
	logic took_free_frame;
	logic [5:0] evicted_process;
	logic [7:0] evicted_page;
	logic write_back;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [8:0] cfg_data = '0;

	// predictor state
	logic       fr_used [cfr_pkg::Frames];
	logic [5:0] fr_owner [cfr_pkg::Frames];
	logic [7:0] fr_page [cfr_pkg::Frames];
	logic       fr_ref [cfr_pkg::Frames];
	logic       fr_dirty [cfr_pkg::Frames];
	int         hand_pos;
	int         frames_cfg;

	fault_res_t pending_results[$];
	int errors = 0;
	bit hold_off = 1'b0;
	bit gap_off = 1'b0;

	always #5 clk = ~clk;

	clock_frame_replacer_core dut (.*);

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
		errors++;
	endtask

	function automatic int eff_count();
		if (frames_cfg == 0) return 1;
		if (frames_cfg > cfr_pkg::Frames) return cfr_pkg::Frames;
		return frames_cfg;
	endfunction

	function automatic void predict_word(input logic kind, input logic [7:0] afr,
			input logic wr, input logic [5:0] fproc, input logic [7:0] fpage,
			input logic isnew, output bit has_res, output fault_res_t r);
		int n, v, h;
		bit found;
		has_res = 0;
		r = '0;
		if (kind == cfr_pkg::ReqAccess) begin
			fr_ref[afr] = 1'b1;
			if (wr) fr_dirty[afr] = 1'b1;
			return;
		end
		n = eff_count();
		found = 0;
		v = 0;
		for (int i = 0; i < n; i++) begin
			if (!found && !fr_used[i]) begin
				v = i;
				found = 1;
			end
		end
		if (found) begin
			r.free = 1'b1;
		end else begin
			h = (hand_pos >= n) ? 0 : hand_pos;
			for (int s = 0; s < 2 * n + 1; s++) begin
				if (!fr_ref[h]) begin
					v = h;
					h = (h + 1) % n;
					break;
				end
				fr_ref[h] = 1'b0;
				h = (h + 1) % n;
			end
			hand_pos = h;
			r.proc_id = fr_owner[v];
			r.page = fr_page[v];
			r.wb = fr_dirty[v];
		end
		r.frame = v[7:0];
		fr_used[v] = 1'b1;
		fr_owner[v] = fproc;
		fr_page[v] = fpage;
		fr_dirty[v] = 1'b0;
		fr_ref[v] = isnew;
		has_res = 1;
	endfunction

	task automatic send_word(input logic kind, input logic [7:0] afr, input logic wr,
			input logic [5:0] fproc, input logic [7:0] fpage, input logic isnew);
		bit has_res;
		fault_res_t r;
		in_valid <= 1'b1;
		req_type <= kind;
		access_frame <= afr;
		access_is_write <= wr;
		fault_process <= fproc;
		fault_page <= fpage;
		page_is_new <= isnew;
		do @(posedge clk); while (!in_ready);
		predict_word(kind, afr, wr, fproc, fpage, isnew, has_res, r);
		if (has_res) pending_results.push_back(r);
	endtask

	task automatic drain();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_count(input logic [8:0] val);
		in_valid <= 1'b0;
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		frames_cfg = val;
	endtask

	// result checker
	always @(posedge clk) begin
		fault_res_t e;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report("unexpected result", chosen_frame, 0);
			end else begin
				e = pending_results.pop_front();
				if (chosen_frame !== e.frame) report("chosen_frame", chosen_frame, e.frame);
				if (took_free_frame !== e.free)
					report("took_free_frame", took_free_frame, e.free);
				if (evicted_process !== e.proc_id)
					report("evicted_process", evicted_process, e.proc_id);
				if (evicted_page !== e.page) report("evicted_page", evicted_page, e.page);
				if (write_back !== e.wb) report("write_back", write_back, e.wb);
			end
		end
	end

	// receiver stall pattern
	initial begin
		int k;
		k = 0;
		forever begin
			@(posedge clk);
			k++;
			if (hold_off) out_ready <= 1'b0;
			else if ((k / 64) % 3 == 0) out_ready <= 1'b1;
			else out_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	initial begin
		#50ms;
		$display("clock_frame_replacer_core test failed");
		$finish;
	end

	// directed rows; expectations typed in where they are obvious
	dir_row_t rows[] = '{
		'{cfr_pkg::ReqFault, 8'd0, 1'b0, 6'd63, 8'd255, 1'b1, 1'b1,
			'{8'd0, 1'b1, 6'd0, 8'd0, 1'b0}},
		'{cfr_pkg::ReqFault, 8'd0, 1'b0, 6'd0, 8'd0, 1'b0, 1'b1,
			'{8'd1, 1'b1, 6'd0, 8'd0, 1'b0}},
		'{cfr_pkg::ReqAccess, 8'd255, 1'b1, 6'd0, 8'd0, 1'b0, 1'b0, '0},
		'{cfr_pkg::ReqAccess, 8'd1, 1'b1, 6'd0, 8'd0, 1'b0, 1'b0, '0},
		'{cfr_pkg::ReqAccess, 8'd0, 1'b0, 6'd0, 8'd0, 1'b0, 1'b0, '0},
		'{cfr_pkg::ReqFault, 8'd0, 1'b0, 6'd21, 8'd170, 1'b0, 1'b1,
			'{8'd2, 1'b1, 6'd0, 8'd0, 1'b0}}
	};

	initial begin
		int burst, n;
		for (int i = 0; i < cfr_pkg::Frames; i++) begin
			fr_used[i] = 0; fr_owner[i] = 0; fr_page[i] = 0; fr_ref[i] = 0; fr_dirty[i] = 0;
		end
		hand_pos = 0;
		frames_cfg = 256;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			send_word(rows[i].kind, rows[i].afr, rows[i].wr, rows[i].fproc,
				rows[i].fpage, rows[i].isnew);
			if (rows[i].chk && pending_results.size() != 0)
				pending_results[$] = rows[i].want;
		end
		// small table: fill it, then evict through the clock hand
		write_count(9'd4);
		for (int i = 0; i < 10; i++)
			send_word(i % 3 == 0 ? cfr_pkg::ReqAccess : cfr_pkg::ReqFault, i[7:0], i[0],
				i[5:0], 8'(i * 37), i[1]);
		write_count(9'd0);
		send_word(cfr_pkg::ReqFault, 8'd0, 1'b0, 6'd5, 8'd6, 1'b1);
		send_word(cfr_pkg::ReqFault, 8'd0, 1'b0, 6'd7, 8'd8, 1'b0);
		write_count(9'd511);
		send_word(cfr_pkg::ReqFault, 8'd0, 1'b0, 6'd42, 8'd1, 1'b0);
		in_valid <= 1'b0;

		// random phases over several frame counts
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: n = 3;
				1: n = 256;
				2: n = 1;
				3: n = 16;
				4: n = 300;
				default: n = $urandom_range(2, 40);
			endcase
			write_count(n[8:0]);
			if (ph == 3) begin
				// long receiver hold-off while words keep coming
				fork
					begin
						hold_off = 1;
						repeat (300) @(posedge clk);
						hold_off = 0;
					end
				join_none
			end
			for (int i = 0; i < 200; i += burst) begin
				burst = $urandom_range(1, 12);
				for (int b = 0; b < burst; b++) begin
					if ($urandom_range(0, 3) == 0)
						send_word(cfr_pkg::ReqFault, 8'($urandom), 1'b0, 6'($urandom),
							8'($urandom), 1'($urandom));
					else
						send_word(cfr_pkg::ReqAccess,
							($urandom_range(0, 4) == 0) ? 8'($urandom) :
								8'($urandom_range(0, (n > 256 ? 256 : n) - 1)),
							1'($urandom), 6'($urandom), 8'($urandom), 1'($urandom));
				end
				if (i % 50 == 0) begin
					in_valid <= 1'b0;
					while (pending_results.size() != 0) @(posedge clk);
				end
				if ($urandom_range(0, 2) != 0) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 6)) @(posedge clk);
				end
			end
			in_valid <= 1'b0;
		end

		fork
			drain();
		join
		if (errors == 0 && pending_results.size() == 0)
			$display("clock_frame_replacer_core test passed");
		else
			$display("clock_frame_replacer_core test failed");
		$finish;
	end

endmodule
